// ===== rtl/ygbd_pkg.sv =====
// shared constants, types and slot decoding for the grid box decoder
`default_nettype none

package ygbd_pkg;

   // detector geometry
   localparam int GRID_SIZE      = 7;
   localparam int BOXES_PER_CELL = 2;
   localparam int CLASS_COUNT    = 20;
   localparam int BOX_FIELDS     = 5;

   // field widths
   localparam int ROW_W     = 3;
   localparam int SLOT_W    = 5;
   localparam int VAL_W     = 16;
   localparam int CLASS_W   = 5;
   localparam int THR_W     = 16;
   localparam int FRAME_W   = 13;
   localparam int FRAC_BITS = 12;
   localparam int BOX_W     = (BOXES_PER_CELL > 1) ? $clog2(BOXES_PER_CELL) : 1;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // datapath widths
   localparam int MUL_W  = 22;             // shared multiplier operand width
   localparam int PROD_W = 2 * MUL_W;
   localparam int BASE_W = VAL_W + 1;      // cell position plus offset
   localparam int SPAN_W = 20;             // 2*(p*4096+o) +/- grid*size
   localparam int NUM_W  = SPAN_W + FRAME_W + 1;
   localparam int DEN_SHIFT = FRAC_BITS + 1;   // power-of-two part of 2*grid*4096
   localparam int M_W    = 19;             // magnitude after the power-of-two shift
   localparam int QUO_W  = 16;
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP  = (2 ** RECIP_SHIFT + GRID_SIZE - 1) / GRID_SIZE;

   // box field positions inside a box's group of slots
   localparam int OFS_CONF = 0;
   localparam int OFS_X    = 1;
   localparam int OFS_Y    = 2;
   localparam int OFS_W    = 3;
   localparam int OFS_H    = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FLD_CLASS,
      FLD_CONF,
      FLD_X,
      FLD_Y,
      FLD_W,
      FLD_H,
      FLD_NONE
   } field_type;

   typedef logic [SLOT_W:0] slot_ext_type;

   typedef struct packed {
      field_type        field;
      logic [BOX_W-1:0] box;
   } slot_info_type;

   typedef struct packed {
      logic [CLASS_W-1:0]      best_class;
      logic signed [VAL_W-1:0] best_score;
      logic signed [VAL_W-1:0] conf;
      logic signed [VAL_W-1:0] x_off;
      logic signed [VAL_W-1:0] y_off;
      logic signed [VAL_W-1:0] width;
   } box_state_type;

   // which field of which box a slot carries
   function automatic slot_info_type decode_slot(input logic [SLOT_W-1:0] slot);
      slot_info_type info;
      slot_ext_type  rel;
      slot_ext_type  lo;
      logic [2:0]    k;
      info.field = FLD_NONE;
      info.box   = '0;
      rel        = {1'b0, slot} - slot_ext_type'(CLASS_COUNT);
      k          = '0;
      if ({1'b0, slot} < slot_ext_type'(CLASS_COUNT)) begin
         info.field = FLD_CLASS;
      end else begin
         for (int b = 0; b < BOXES_PER_CELL; b++) begin
            lo = slot_ext_type'(BOX_FIELDS * b);
            if (rel >= lo && rel < lo + slot_ext_type'(BOX_FIELDS)) begin
               info.box = BOX_W'(b);
               k        = 3'(rel - lo);
               case (k)
                  3'(OFS_CONF): info.field = FLD_CONF;
                  3'(OFS_X):    info.field = FLD_X;
                  3'(OFS_Y):    info.field = FLD_Y;
                  3'(OFS_W):    info.field = FLD_W;
                  3'(OFS_H):    info.field = FLD_H;
                  default:      info.field = FLD_NONE;
               endcase
            end
         end
      end
      return info;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ygbd_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none

module ygbd_mul (
   input  wire logic                                  clock,
   input  wire logic signed [ygbd_pkg::MUL_W-1:0]     op_a,
   input  wire logic signed [ygbd_pkg::MUL_W-1:0]     op_b,
   output logic signed [ygbd_pkg::PROD_W-1:0]         product
);
   import ygbd_pkg::*;

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== rtl/ygbd_track.sv =====
// running class argmax and current box fields of a cell
`default_nettype none

module ygbd_track (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 update,
   input  wire logic [ygbd_pkg::SLOT_W-1:0]          slot,
   input  wire logic signed [ygbd_pkg::VAL_W-1:0]    value,
   output ygbd_pkg::box_state_type                   box_state
);
   import ygbd_pkg::*;

   box_state_type state_ff;
   box_state_type state_in;
   slot_info_type info;

   always_comb begin
      info     = decode_slot(slot);
      state_in = state_ff;
      if (update) begin
         case (info.field)
            FLD_CLASS: begin
               // first class slot restarts the argmax, ties keep the earlier class
               if (slot == '0 || value > state_ff.best_score) begin
                  state_in.best_class = CLASS_W'(slot);
                  state_in.best_score = value;
               end
            end
            FLD_CONF: state_in.conf  = value;
            FLD_X:    state_in.x_off = value;
            FLD_Y:    state_in.y_off = value;
            FLD_W:    state_in.width = value;
            default:  state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.best_class <= '0;
         state_ff.best_score <= {1'b1, {(VAL_W-1){1'b0}}};
         state_ff.conf       <= '0;
         state_ff.x_off      <= '0;
         state_ff.y_off      <= '0;
         state_ff.width      <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign box_state = state_ff;

endmodule

`default_nettype wire

// ===== rtl/yolo_grid_box_decoder.sv =====
// grid box decoder top level: sequencer, corner datapath and stream ports
//
// usage
//   req_ carries one prediction value of a grid cell per item, tagged with its
//   row, column and slot. class slots update a running argmax, box slots load
//   conf, x, y and w. these do not stall the input: req_tready stays high.
//   an item on a box's h slot starts the decode: score = conf * best class
//   score through the shared multiplier, compared with score_threshold. a box
//   that fails holds req_tready low through S_SCORE_MUL and S_SCORE_CHK and gives
//   nothing. a box that passes gets its four corners, each as four steps around
//   the shared multiplier (numerator, magnitude, reciprocal multiply by 1/grid,
//   saturate), then S_OUT loads the result; req_tready stays low from the edge
//   that took the h item until that load, and rsp_tvalid rises with it.
//   rsp_ is a single output register: while it holds an item the block still
//   takes class and box items; a finished box waits until the register is free
//   or rsp_tready is high before it is loaded, holding req_tready low.
//   csr_ writes the threshold and frame sizes; the user writes them only while
//   the block is idle, which the block itself does not enforce.
//   reset (synchronous) clears the argmax, the box fields, the sequencer and
//   rsp_tvalid, and loads threshold 614 and a 448 x 448 frame.
`default_nettype none

module yolo_grid_box_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // config write port
   input  wire logic                                 csr_we,
   input  wire logic [ygbd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ygbd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // input items
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // cell_row[2:0], cell_col[5:3], slot[10:6], value[26:11], zero[31:27]
   input  wire logic [ygbd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result items
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // out_row[2:0], out_col[5:3], box_index[6], label[11:7], score[27:12],
   // x_left[43:28], y_top[59:44], x_right[75:60], y_bottom[91:76], zero[95:92]
   output logic [ygbd_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import ygbd_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SCORE_MUL = 8'b0000_0010,
      S_SCORE_CHK = 8'b0000_0100,
      S_NUM_MUL   = 8'b0000_1000,
      S_ABS       = 8'b0001_0000,
      S_DIV_MUL   = 8'b0010_0000,
      S_SAVE      = 8'b0100_0000,
      S_OUT       = 8'b1000_0000
   } state_type;

   // request fields
   logic [ROW_W-1:0]        req_row;
   logic [ROW_W-1:0]        req_col;
   logic [SLOT_W-1:0]       req_slot;
   logic signed [VAL_W-1:0] req_value;
   logic                    req_accept;
   slot_info_type           req_info;

   assign req_row    = req_tdata[2:0];
   assign req_col    = req_tdata[5:3];
   assign req_slot   = req_tdata[10:6];
   assign req_value  = req_tdata[26:11];
   assign req_accept = req_tvalid && req_tready;
   assign req_info   = decode_slot(req_slot);

   // control registers
   state_type          state_ff,  state_in;
   logic [1:0]         corner_ff, corner_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [FRAME_W-1:0] fw_ff,  fw_in;
   logic [FRAME_W-1:0] fh_ff,  fh_in;

   // payload registers
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [ROW_W-1:0]        col_ff, col_in;
   logic [BOX_W-1:0]        box_ff, box_in;
   logic signed [VAL_W-1:0] h_ff, h_in;
   logic                    neg_ff, neg_in;
   logic [M_W-1:0]          m_ff, m_in;
   logic [VAL_W-1:0]        score_ff, score_in;
   logic [VAL_W-1:0]        corner_val_ff [4];
   logic [VAL_W-1:0]        corner_val_in [4];
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  op_a;
   logic signed [MUL_W-1:0]  op_b;
   logic signed [PROD_W-1:0] product;

   box_state_type box_state;

   // datapath nets
   logic                     score_pass;
   logic [ROW_W-1:0]         pos;
   logic signed [VAL_W-1:0]  offs;
   logic signed [VAL_W-1:0]  size;
   logic [FRAME_W-1:0]       frame_sel;
   logic signed [BASE_W-1:0] base;
   logic signed [SPAN_W-1:0] twice;
   logic signed [SPAN_W-1:0] size_ext;
   logic signed [SPAN_W-1:0] size_grid;
   logic signed [SPAN_W-1:0] span;
   logic [NUM_W-1:0]         num;
   logic [NUM_W-1:0]         mag;
   logic [QUO_W-1:0]         quo;
   logic [VAL_W-1:0]         corner_sat;
   logic                     out_free;

   ygbd_track u_track (
      .clock     (clock),
      .reset     (reset),
      .update    (req_accept),
      .slot      (req_slot),
      .value     (req_value),
      .box_state (box_state)
   );

   ygbd_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // corner geometry: bit 0 of the corner count picks the axis, bit 1 the sign
   always_comb begin
      pos       = corner_ff[0] ? row_ff : col_ff;
      offs      = corner_ff[0] ? box_state.y_off : box_state.x_off;
      size      = corner_ff[0] ? h_ff : box_state.width;
      frame_sel = corner_ff[0] ? fh_ff : fw_ff;
      base      = $signed({2'b00, pos, {FRAC_BITS{1'b0}}}) + $signed({offs[VAL_W-1], offs});
      twice     = {{(SPAN_W-BASE_W-1){base[BASE_W-1]}}, base, 1'b0};
      size_ext  = {{(SPAN_W-VAL_W){size[VAL_W-1]}}, size};
      size_grid = size_ext * SPAN_W'(GRID_SIZE);
      span      = corner_ff[1] ? twice + size_grid : twice - size_grid;
   end

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_SCORE_MUL: begin
            op_a = {{(MUL_W-VAL_W){box_state.conf[VAL_W-1]}}, box_state.conf};
            op_b = {{(MUL_W-VAL_W){box_state.best_score[VAL_W-1]}}, box_state.best_score};
         end
         S_NUM_MUL: begin
            op_a = {{(MUL_W-SPAN_W){span[SPAN_W-1]}}, span};
            op_b = {{(MUL_W-FRAME_W){1'b0}}, frame_sel};
         end
         S_DIV_MUL: begin
            op_a = {{(MUL_W-M_W){1'b0}}, m_ff};
            op_b = MUL_W'(RECIP);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // score test and result shaping
   always_comb begin
      score_pass = product >= $signed({{(PROD_W-THR_W-FRAC_BITS){1'b0}}, thr_ff,
                                       {FRAC_BITS{1'b0}}});
      num = product[NUM_W-1:0];
      mag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
      quo = product[RECIP_SHIFT +: QUO_W];
      // truncate toward zero: floor of the magnitude, then the sign back on
      if (!neg_ff) begin
         corner_sat = quo[QUO_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : quo;
      end else begin
         corner_sat = (quo > {1'b1, {(QUO_W-1){1'b0}}}) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                       : (~quo + QUO_W'(1));
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer and register next values
   always_comb begin
      state_in      = state_ff;
      corner_in     = corner_ff;
      rsp_valid_in  = rsp_valid_ff;
      thr_in        = thr_ff;
      fw_in         = fw_ff;
      fh_in         = fh_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      box_in        = box_ff;
      h_in          = h_ff;
      neg_in        = neg_ff;
      m_in          = m_ff;
      score_in      = score_ff;
      corner_val_in = corner_val_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD:    thr_in = csr_wdata[THR_W-1:0];
            CSR_FRAME_WIDTH:  fw_in  = csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: fh_in  = csr_wdata[FRAME_W-1:0];
            default:          thr_in = thr_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_info.field == FLD_H) begin
               row_in   = req_row;
               col_in   = req_col;
               box_in   = req_info.box;
               h_in     = req_value;
               state_in = S_SCORE_MUL;
            end
         end
         S_SCORE_MUL: begin
            state_in = S_SCORE_CHK;
         end
         S_SCORE_CHK: begin
            // a passing product is never negative, so only the top saturates
            if (product[PROD_W-1:FRAC_BITS+VAL_W-1] != '0) begin
               score_in = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
               score_in = product[FRAC_BITS +: VAL_W];
            end
            corner_in = '0;
            state_in  = score_pass ? S_NUM_MUL : S_IDLE;
         end
         S_NUM_MUL: begin
            state_in = S_ABS;
         end
         S_ABS: begin
            neg_in   = num[NUM_W-1];
            m_in     = mag[DEN_SHIFT +: M_W];
            state_in = S_DIV_MUL;
         end
         S_DIV_MUL: begin
            state_in = S_SAVE;
         end
         S_SAVE: begin
            corner_val_in[corner_ff] = corner_sat;
            corner_in = corner_ff + 2'd1;
            state_in  = (corner_ff == 2'd3) ? S_OUT : S_NUM_MUL;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, corner_val_ff[3], corner_val_ff[2],
                               corner_val_ff[1], corner_val_ff[0], score_ff,
                               box_state.best_class, box_ff[0], col_ff, row_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_W'(614);
         fw_ff        <= FRAME_W'(448);
         fh_ff        <= FRAME_W'(448);
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      box_ff        <= box_in;
      h_ff          <= h_in;
      neg_ff        <= neg_in;
      m_ff          <= m_in;
      score_ff      <= score_in;
      corner_val_ff <= corner_val_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a box below threshold goes straight back to idle
   a_fail_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCORE_CHK && !score_pass) |=> state_ff == S_IDLE)
      else $error("failed box did not return to idle");

   // the fourth saved corner hands over to the output stage
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAVE && corner_ff == 2'd3) |=> state_ff == S_OUT)
      else $error("corner sequence did not end in output stage");

   // a new result only comes from the output stage
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside output stage");

   // kept boxes passed a non-negative threshold, so the score is never negative
   a_score_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_data_ff[27])
      else $error("negative score on result");

endmodule

`default_nettype wire

// ===== tb/ygbd_detection_checker.sv =====
// detection checker: watches the value and detection streams, predicts boxes and compares
`default_nettype none

module ygbd_detection_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [ygbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ygbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [ygbd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [ygbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   detections_seen
);

   import ygbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the registers
   logic [THR_W-1:0]   threshold;
   logic [FRAME_W-1:0] frame_w;
   logic [FRAME_W-1:0] frame_h;

   // shadow copy of the running cell state
   logic [CLASS_W-1:0]      best_class;
   logic signed [VAL_W-1:0] best_score;
   logic signed [VAL_W-1:0] box_conf;
   logic signed [VAL_W-1:0] box_x;
   logic signed [VAL_W-1:0] box_y;
   logic signed [VAL_W-1:0] box_wid;

   // detections still owed by the block, packed as on rsp_tdata
   logic [RSP_DATA_W-1:0] due_boxes[$];

   logic [RSP_DATA_W-1:0] want;
   logic [RSP_DATA_W-1:0] mask;
   int                    lsb;
   int                    wid;
   string                 nm;

   function automatic logic [15:0] clamp16(input longint v);
      if (v > 32767)
         return 16'h7FFF;
      if (v < -32768)
         return 16'h8000;
      return v[15:0];
   endfunction

   // (2*(p*4096 + o) +/- grid*size) * frame / (2*grid*4096), truncated toward zero
   function automatic logic [15:0] pixel_corner(input int pos, input logic signed [15:0] off,
                                                input logic signed [15:0] size, input int sgn,
                                                input logic [FRAME_W-1:0] frame);
      longint frame64;
      longint num;
      frame64 = frame;
      num = (2 * (longint'(pos) * 4096 + off) + sgn * GRID_SIZE * size) * frame64;
      return clamp16(num / (2 * GRID_SIZE * 4096));
   endfunction

   task automatic decode_value(input logic [REQ_DATA_W-1:0] item);
      logic [2:0]              row;
      logic [2:0]              col;
      logic [SLOT_W-1:0]       slot;
      logic signed [VAL_W-1:0] value;
      int                      rel;
      int                      b;
      longint                  prod;
      longint                  thr64;
      logic [RSP_DATA_W-1:0]   det;
      row   = item[2:0];
      col   = item[5:3];
      slot  = item[10:6];
      value = item[26:11];
      if (slot < CLASS_COUNT) begin
         // slot 0 restarts the argmax, later ties keep the earlier class
         if (slot == 0 || value > best_score) begin
            best_score = value;
            best_class = slot;
         end
         return;
      end
      rel = int'(slot) - CLASS_COUNT;
      if (rel >= BOX_FIELDS * BOXES_PER_CELL)
         return;
      b = rel / BOX_FIELDS;
      case (rel % BOX_FIELDS)
         OFS_CONF: box_conf = value;
         OFS_X:    box_x = value;
         OFS_Y:    box_y = value;
         OFS_W:    box_wid = value;
         default: begin
            prod  = longint'(box_conf) * longint'(best_score);
            thr64 = threshold;
            if (prod >= thr64 * 4096) begin
               det         = '0;
               det[2:0]    = row;
               det[5:3]    = col;
               det[6]      = b[0];
               det[11:7]   = best_class;
               det[27:12]  = clamp16(prod / 4096);
               det[43:28]  = pixel_corner(col, box_x, box_wid, -1, frame_w);
               det[59:44]  = pixel_corner(row, box_y, value, -1, frame_h);
               det[75:60]  = pixel_corner(col, box_x, box_wid, 1, frame_w);
               det[91:76]  = pixel_corner(row, box_y, value, 1, frame_h);
               due_boxes.push_back(det);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold       = 16'd614;
         frame_w         = 13'd448;
         frame_h         = 13'd448;
         best_class      = '0;
         best_score      = 16'sh8000;
         box_conf        = '0;
         box_x           = '0;
         box_y           = '0;
         box_wid         = '0;
         fail_count      = 0;
         detections_seen = 0;
         due_boxes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD:    threshold = csr_wdata;
               CSR_FRAME_WIDTH:  frame_w = csr_wdata[FRAME_W-1:0];
               CSR_FRAME_HEIGHT: frame_h = csr_wdata[FRAME_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_boxes.size() == 0) begin
               $display("%0t ns: unexpected detection, expected none, actual 0x%h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = due_boxes.pop_front();
               for (int i = 0; i < 10; i++) begin
                  case (i)
                     0: begin lsb = 0;  wid = 3;  nm = "out_row";   end
                     1: begin lsb = 3;  wid = 3;  nm = "out_col";   end
                     2: begin lsb = 6;  wid = 1;  nm = "box_index"; end
                     3: begin lsb = 7;  wid = 5;  nm = "label";     end
                     4: begin lsb = 12; wid = 16; nm = "score";     end
                     5: begin lsb = 28; wid = 16; nm = "x_left";    end
                     6: begin lsb = 44; wid = 16; nm = "y_top";     end
                     7: begin lsb = 60; wid = 16; nm = "x_right";   end
                     8: begin lsb = 76; wid = 16; nm = "y_bottom";  end
                     default: begin lsb = 92; wid = 4; nm = "pad"; end
                  endcase
                  mask = ~({RSP_DATA_W{1'b1}} << wid);
                  if (((want >> lsb) & mask) != ((rsp_tdata >> lsb) & mask)) begin
                     $display("%0t ns: detection %0d %s expected 0x%0h, actual 0x%0h",
                              $time, detections_seen, nm, (want >> lsb) & mask,
                              (rsp_tdata >> lsb) & mask);
                     fail_count++;
                  end
               end
               detections_seen++;
            end
         end
         if (req_tvalid && req_tready)
            decode_value(req_tdata);
      end
      pending = due_boxes.size();
   end

endmodule

`default_nettype wire

// ===== tb/yolo_grid_box_decoder_tb.sv =====
// top of the grid box decoder testbench: clock, reset, stimulus, register phases and verdict
`default_nettype none

module yolo_grid_box_decoder_tb;

   import ygbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // slots carried by one well-formed cell: class scores, then the box groups
   localparam int SLOTS_PER_CELL = CLASS_COUNT + BOX_FIELDS * BOXES_PER_CELL;
   // random phases, each with its own register setting
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 260;
   // long enough for a passing or a failing box to finish
   localparam int SETTLE_CYCLES  = 24;
   // receiver hold-off used to back the block up into its input
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 500000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int detections_seen;

   // idle odds in percent for each side, changed per phase
   int tx_idle = 28;
   int rx_idle = 28;
   // asks the receiver for one long hold-off
   bit hold_req = 1'b0;
   int hold_cnt = 0;

   int values_sent = 0;
   int cycle_count = 0;

   yolo_grid_box_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ygbd_detection_checker det_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .detections_seen (detections_seen)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // detection receiver: random back-pressure, plus one long hold-off when asked;
   // the hold-off is counted here so the sender keeps running meanwhile
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // slot number of field k of box b
   function automatic logic [SLOT_W-1:0] box_slot(input int b, input int k);
      return SLOT_W'(CLASS_COUNT + BOX_FIELDS * b + k);
   endfunction

   // mostly in-grid cells, now and then the unused row or column 7
   function automatic logic [ROW_W-1:0] pick_coord();
      if ($urandom_range(19) == 0)
         return 3'd7;
      return ROW_W'($urandom_range(GRID_SIZE - 1));
   endfunction

   // values lean positive so that most boxes clear the threshold, with extremes mixed in
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:          return 16'h8000;
         1:          return 16'h7FFF;
         2:          return 16'h0000;
         3, 4, 5, 6: return VAL_W'($urandom_range(32767));
         default:    return VAL_W'($urandom);
      endcase
   endfunction

   // offer one value and hold it until the block takes it; valid only drops for a gap
   task automatic push_value(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col,
                             input logic [SLOT_W-1:0] slot, input logic [VAL_W-1:0] value);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, value, slot, col, row};
      do @(posedge clock); while (!req_tready);
      if (slot < SLOTS_PER_CELL)
         values_sent++;
   endtask

   // one cell vector in slot order; a broken one drops a slot and hops to another cell midway
   task automatic send_cell(input bit broken);
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      int               drop;
      int               hop;
      row  = pick_coord();
      col  = pick_coord();
      drop = broken ? $urandom_range(SLOTS_PER_CELL - 1) : -1;
      hop  = broken ? $urandom_range(1, SLOTS_PER_CELL - 1) : -1;
      for (int s = 0; s < SLOTS_PER_CELL; s++) begin
         if (s == hop) begin
            row = pick_coord();
            col = pick_coord();
         end
         if (s != drop)
            push_value(row, col, SLOT_W'(s), pick_value());
      end
   endtask

   // let every owed detection come out, then give a failing box time to finish;
   // first wait on the clock so the checker has seen the last item taken
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] fw;
      logic [CSR_DATA_W-1:0] fh;
      int                    target;
      int                    pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset registers: threshold 614, 448 x 448 frame

      // argmax: slot 0 at the most negative value, a tie between two maxima keeps the first
      push_value(3'd0, 3'd0, 5'd0, 16'h8000);
      push_value(3'd0, 3'd0, 5'd1, 16'h7FFF);
      push_value(3'd0, 3'd0, 5'd2, 16'h7FFF);
      push_value(3'd0, 3'd0, SLOT_W'(CLASS_COUNT - 1), 16'h0001);
      // box 0 at full scale: score saturates, extreme offsets and sizes
      push_value(3'd0, 3'd0, box_slot(0, OFS_CONF), 16'h7FFF);
      push_value(3'd0, 3'd0, box_slot(0, OFS_X), 16'h7FFF);
      push_value(3'd0, 3'd0, box_slot(0, OFS_Y), 16'h8000);
      push_value(3'd0, 3'd0, box_slot(0, OFS_W), 16'h7FFF);
      push_value(3'd0, 3'd0, box_slot(0, OFS_H), 16'h7FFF);
      // box 1 with a negative confidence gives nothing
      push_value(3'd0, 3'd0, box_slot(1, OFS_CONF), 16'h8000);
      push_value(3'd0, 3'd0, box_slot(1, OFS_X), 16'h0000);
      push_value(3'd0, 3'd0, box_slot(1, OFS_Y), 16'h0000);
      push_value(3'd0, 3'd0, box_slot(1, OFS_W), 16'h0000);
      push_value(3'd0, 3'd0, box_slot(1, OFS_H), 16'h1000);
      // slots past the last box are ignored
      push_value(3'd0, 3'd0, SLOT_W'(SLOTS_PER_CELL), 16'h5A5A);
      push_value(3'd7, 3'd7, 5'd31, 16'hFFFF);
      // both at the most negative value: largest product; h comes from row and column 7
      push_value(3'd6, 3'd6, 5'd0, 16'h8000);
      push_value(3'd6, 3'd6, box_slot(1, OFS_CONF), 16'h8000);
      push_value(3'd6, 3'd6, box_slot(1, OFS_X), 16'h0800);
      push_value(3'd6, 3'd6, box_slot(1, OFS_W), 16'h0000);
      push_value(3'd7, 3'd7, box_slot(1, OFS_H), 16'h8000);
      // product exactly at the threshold passes, one step below fails
      push_value(3'd3, 3'd4, 5'd0, 16'h1000);
      push_value(3'd3, 3'd4, box_slot(0, OFS_CONF), 16'd614);
      push_value(3'd3, 3'd4, box_slot(0, OFS_H), 16'h2000);
      push_value(3'd3, 3'd4, box_slot(0, OFS_CONF), 16'd613);
      push_value(3'd3, 3'd4, box_slot(0, OFS_H), 16'h2000);
      finish_phase();

      // random phases, one register setting each
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               thr = 16'd614;
               fw  = 16'd448;
               fh  = 16'd448;
            end
            1: begin
               // largest frames, threshold off, and a long stretch with no idling
               thr     = 16'd0;
               fw      = 16'd8191;
               fh      = 16'd8191;
               tx_idle = 0;
               rx_idle = 0;
            end
            2: begin
               // receiver holds off for a while so the block backs up into its input
               thr      = CSR_DATA_W'($urandom_range(4095));
               fw       = CSR_DATA_W'($urandom_range(1, 8191));
               fh       = CSR_DATA_W'($urandom_range(1, 8191));
               tx_idle  = 0;
               hold_req = 1'b1;
            end
            3: begin
               thr = 16'hFFFF;
               fw  = 16'd1;
               fh  = 16'd1;
            end
            4: begin
               // upper bits land outside the 13-bit frame registers, leaving zero frames
               thr = 16'd0;
               fw  = 16'hE000;
               fh  = 16'h2000;
            end
            default: begin
               thr = CSR_DATA_W'($urandom_range(8191));
               fw  = {3'($urandom), 13'($urandom_range(1, 8191))};
               fh  = {3'($urandom), 13'($urandom_range(1, 8191))};
            end
         endcase

         // all three registers, back to back while the block is idle
         csr_we    <= 1'b1;
         csr_index <= CSR_THRESHOLD;
         csr_wdata <= thr;
         @(posedge clock);
         csr_index <= CSR_FRAME_WIDTH;
         csr_wdata <= fw;
         @(posedge clock);
         csr_index <= CSR_FRAME_HEIGHT;
         csr_wdata <= fh;
         @(posedge clock);
         csr_we    <= 1'b0;

         // mostly whole cells, some broken ones, the rest stray values on any slot
         target = values_sent + PHASE_ITEMS;
         while (values_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75)
               send_cell(1'b0);
            else if (pick < 87)
               send_cell(1'b1);
            else
               repeat ($urandom_range(1, 5))
                  push_value(pick_coord(), pick_coord(), SLOT_W'($urandom_range(31)),
                             VAL_W'($urandom));
         end
         finish_phase();
         tx_idle  = 28;
         rx_idle  = 28;
         hold_req = 1'b0;
      end

      $display("covered %0d values: directed cells and %0d register settings,", values_sent,
               PHASES);
      $display("including threshold and frame extremes and a long receiver hold-off; %0d boxes",
               detections_seen);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== yolo_grid_box_decoder.f =====
rtl/ygbd_pkg.sv
rtl/ygbd_mul.sv
rtl/ygbd_track.sv
rtl/yolo_grid_box_decoder.sv
tb/ygbd_detection_checker.sv
tb/yolo_grid_box_decoder_tb.sv
